>>> hw/rtl/gsp_pkg.sv
// Shared types and constants for the graph shortest path engine.
// Used by gsp_ctrl, gsp_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

  localparam int NUM_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 15;

  localparam int OP_W   = 3;
  localparam int ID_W   = 6;
  localparam int WRAW_W = 16;
  localparam int DIST_W = 21;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_VINS = 3'd0,
    OP_VDEL = 3'd1,
    OP_EINS = 3'd2,
    OP_EDEL = 3'd3,
    OP_QRY  = 3'd4
  } op_e;

  // edge store write source
  typedef enum logic [2:0] {
    EW_NONE,
    EW_CLEAR,
    EW_INS,
    EW_DEL,
    EW_ROW,
    EW_COL
  } ew_sel_e;

  typedef struct packed {
    logic    cnt_clr;
    logic    cnt_inc;
    logic    latch;
    logic    vset;
    logic    vclr;
    logic    vis_clr;
    logic    vis_set;
    logic    dist_init;
    logic    scan_init;
    logic    scan_rd;
    logic    relax_rd;
    ew_sel_e ew_sel;
    logic    res_set;
    logic    res_ok;
    logic    res_len_dist;
    logic    out_load;
  } gsp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic clr_last;
    logic vtx_last;
    logic a_range;
    logic a_pres;
    logic b_pres;
    logic w_ok;
    logic edge_hit;
    logic best_valid;
    logic reached;
    logic out_free;
  } gsp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/gsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/gsp_dp.sv
// Datapath: vertex flags, edge and distance memories, sweep counter,
// minimum search and relaxation. Depends on gsp_pkg and gsp_ram.
`timescale 1ns / 1ps
`default_nettype none

module gsp_dp import gsp_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gsp_cmd_t                 cmd_i,
  output gsp_stat_t                     stat_o,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic [ID_W-1:0]          from_vertex_i,
  input  wire logic [ID_W-1:0]          to_vertex_i,
  input  wire logic signed [WRAW_W-1:0] weight_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic                          status_o,
  output logic [DIST_W-1:0]             path_length_o
);

  localparam int VID_W = $clog2(NUM_VERTICES);
  localparam int CNT_W = 2 * VID_W;
  localparam int EW    = WEIGHT_BITS + 1;
  localparam int EDEPTH = 1 << CNT_W;
  localparam int SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;
  localparam logic [8:0]  NV9    = 9'(NUM_VERTICES);
  localparam logic [31:0] WMAX32 = 32'((33'd1 << WEIGHT_BITS) - 33'd1);
  localparam logic [VID_W-1:0] VLAST = VID_W'(NUM_VERTICES - 1);

  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   a_q, b_q;
  logic [WRAW_W-1:0] w_q;
  logic [NUM_VERTICES-1:0] vpres_q, vis_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [VID_W-1:0]  best_q;
  logic              best_valid_q;
  logic [DIST_W-1:0] best_d_q;
  logic              pipe_scan_q, pipe_relax_q;
  logic [VID_W-1:0]  pipe_idx_q;
  logic              res_ok_q;
  logic [DIST_W-1:0] res_len_q;

  logic [8:0]        a_ext, b_ext;
  logic [VID_W-1:0]  a_idx, b_idx, cnt_v;
  logic              a_range, b_range;
  logic [31:0]       w32;

  logic              e_we;
  logic [CNT_W-1:0]  e_waddr, e_raddr;
  logic [EW-1:0]     e_wdata, e_rdata;

  logic              d_we;
  logic [VID_W-1:0]  d_waddr, d_raddr;
  logic [DIST_W-1:0] d_wdata, d_rdata;

  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] cand;
  logic              upd, scan_hit;

  assign a_ext   = {3'b000, a_q};
  assign b_ext   = {3'b000, b_q};
  assign a_range = a_ext < NV9;
  assign b_range = b_ext < NV9;
  assign a_idx   = a_ext[VID_W-1:0];
  assign b_idx   = b_ext[VID_W-1:0];
  assign cnt_v   = cnt_q[VID_W-1:0];
  assign w32     = {16'd0, w_q};

  // edge store: {present, weight}
  always_comb begin
    e_we    = 1'b1;
    e_waddr = {a_idx, b_idx};
    e_wdata = '0;
    case (cmd_i.ew_sel)
      EW_CLEAR: e_waddr = cnt_q;
      EW_INS:   e_wdata = {1'b1, w32[WEIGHT_BITS-1:0]};
      EW_DEL:   e_waddr = {a_idx, b_idx};
      EW_ROW:   e_waddr = {a_idx, cnt_v};
      EW_COL:   e_waddr = {cnt_v, a_idx};
      default:  e_we = 1'b0;
    endcase
  end

  assign e_raddr = cmd_i.relax_rd ? {best_q, cnt_v} : {a_idx, b_idx};

  gsp_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  // relaxation, saturating one below infinity
  assign sum  = SUM_W'(best_d_q) + SUM_W'(e_rdata[WEIGHT_BITS-1:0]);
  assign cand = (sum > SUM_W'(DIST_INF - 1'b1)) ? (DIST_INF - 1'b1) : sum[DIST_W-1:0];
  assign upd  = pipe_relax_q && e_rdata[EW-1] && vpres_q[pipe_idx_q] && (d_rdata > cand);
  assign scan_hit = pipe_scan_q && vpres_q[pipe_idx_q] && !vis_q[pipe_idx_q] &&
                    (d_rdata < best_d_q);

  assign d_we    = cmd_i.dist_init || upd;
  assign d_waddr = cmd_i.dist_init ? cnt_v : pipe_idx_q;
  assign d_wdata = cmd_i.dist_init ? ((cnt_v == a_idx) ? '0 : DIST_INF) : cand;
  assign d_raddr = (cmd_i.scan_rd || cmd_i.relax_rd) ? cnt_v : b_idx;

  gsp_ram #(.WIDTH(DIST_W), .DEPTH(NUM_VERTICES)) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= op_i;
      a_q  <= from_vertex_i;
      b_q  <= to_vertex_i;
      w_q  <= $unsigned(weight_i);
    end
    if (cmd_i.scan_init) begin
      best_d_q <= DIST_INF;
    end else if (scan_hit) begin
      best_d_q <= d_rdata;
      best_q   <= pipe_idx_q;
    end
    if (cmd_i.res_set) begin
      res_ok_q  <= cmd_i.res_ok;
      res_len_q <= cmd_i.res_len_dist ? d_rdata : '0;
    end
    if (cmd_i.out_load) begin
      status_o      <= !res_ok_q;
      path_length_o <= res_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpres_q      <= '0;
      vis_q        <= '0;
      cnt_q        <= '0;
      best_valid_q <= 1'b0;
      pipe_scan_q  <= 1'b0;
      pipe_relax_q <= 1'b0;
      pipe_idx_q   <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.vset && a_range) begin
        vpres_q[a_idx] <= 1'b1;
      end
      if (cmd_i.vclr && a_range) begin
        vpres_q[a_idx] <= 1'b0;
      end
      if (cmd_i.vis_clr) begin
        vis_q <= '0;
      end else if (cmd_i.vis_set) begin
        vis_q[best_q] <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        best_valid_q <= 1'b0;
      end else if (scan_hit) begin
        best_valid_q <= 1'b1;
      end
      pipe_scan_q  <= cmd_i.scan_rd;
      pipe_relax_q <= cmd_i.relax_rd;
      pipe_idx_q   <= cnt_v;
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.clr_last   = &cnt_q;
    stat_o.vtx_last   = cnt_v == VLAST;
    stat_o.a_range    = a_range;
    stat_o.a_pres     = a_range && vpres_q[a_idx];
    stat_o.b_pres     = b_range && vpres_q[b_idx];
    stat_o.w_ok       = !w_q[WRAW_W-1] && (w32 <= WMAX32);
    stat_o.edge_hit   = e_rdata[EW-1];
    stat_o.best_valid = best_valid_q;
    stat_o.reached    = d_rdata != DIST_INF;
    stat_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/gsp_ctrl.sv
// Controller: sequences updates, the reset clearing pass and the query rounds.
// Depends on gsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsp_ctrl import gsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire gsp_stat_t stat_i,
  output gsp_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_VDEL_ROW, ST_VDEL_COL, ST_EDGE_RD, ST_EDGE_WR,
    ST_Q_INIT, ST_Q_SCAN, ST_Q_SCAN_END, ST_Q_PICK, ST_Q_RELAX, ST_Q_RELAX_END,
    ST_Q_FIN_RD, ST_Q_FIN, ST_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    cmd_o   = '0;
    cmd_o.ew_sel = EW_NONE;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.ew_sel  = EW_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.res_set = 1'b1;
        state_d       = ST_RESP;
        case (stat_i.op)
          OP_VINS: begin
            if (stat_i.a_range && !stat_i.a_pres) begin
              cmd_o.vset   = 1'b1;
              cmd_o.res_ok = 1'b1;
            end
          end
          OP_VDEL: begin
            if (stat_i.a_pres) begin
              cmd_o.res_set = 1'b0;
              state_d       = ST_VDEL_ROW;
            end
          end
          OP_EINS: begin
            if (stat_i.a_pres && stat_i.b_pres && stat_i.w_ok) begin
              cmd_o.res_set = 1'b0;
              state_d       = ST_EDGE_RD;
            end
          end
          OP_EDEL: begin
            if (stat_i.a_pres && stat_i.b_pres) begin
              cmd_o.ew_sel = EW_DEL;
              cmd_o.res_ok = 1'b1;
            end
          end
          OP_QRY: begin
            if (stat_i.a_pres && stat_i.b_pres) begin
              cmd_o.res_set = 1'b0;
              cmd_o.vis_clr = 1'b1;
              state_d       = ST_Q_INIT;
            end
          end
          default: ;
        endcase
      end
      ST_VDEL_ROW: begin
        cmd_o.ew_sel  = EW_ROW;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.vtx_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_VDEL_COL;
        end
      end
      ST_VDEL_COL: begin
        cmd_o.ew_sel  = EW_COL;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.vtx_last) begin
          cmd_o.vclr    = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.res_ok  = 1'b1;
          state_d       = ST_RESP;
        end
      end
      ST_EDGE_RD: state_d = ST_EDGE_WR;
      ST_EDGE_WR: begin
        cmd_o.res_set = 1'b1;
        if (!stat_i.edge_hit) begin
          cmd_o.ew_sel = EW_INS;
          cmd_o.res_ok = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_Q_INIT: begin
        cmd_o.dist_init = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (stat_i.vtx_last) begin
          cmd_o.cnt_clr   = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = ST_Q_SCAN;
        end
      end
      ST_Q_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.vtx_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_Q_SCAN_END;
        end
      end
      ST_Q_SCAN_END: state_d = ST_Q_PICK;
      ST_Q_PICK: begin
        if (stat_i.best_valid) begin
          cmd_o.vis_set = 1'b1;
          state_d       = ST_Q_RELAX;
        end else begin
          state_d = ST_Q_FIN_RD;
        end
      end
      ST_Q_RELAX: begin
        cmd_o.relax_rd = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.vtx_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_Q_RELAX_END;
        end
      end
      ST_Q_RELAX_END: begin
        cmd_o.scan_init = 1'b1;
        state_d         = ST_Q_SCAN;
      end
      ST_Q_FIN_RD: state_d = ST_Q_FIN;
      ST_Q_FIN: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_ok       = stat_i.reached;
        cmd_o.res_len_dist = stat_i.reached;
        state_d            = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/graph_shortest_path_engine.sv
// Top level of the graph shortest path engine: controller plus datapath.
// Depends on gsp_pkg, gsp_ctrl, gsp_dp (and gsp_ram through gsp_dp).
//
//   channel | handshake              | payload
//   in      | in_valid_i / in_ready_o | op_i, from_vertex_i, to_vertex_i, weight_i
//   out     | out_valid_o/out_ready_i | status_o, path_length_o
//
// Vertex remove clears its row and then its column in the edge memory. A query
// runs rounds of a minimum scan and a relaxation sweep, one round per reachable
// vertex plus a final scan; the edge and distance memories, one read port each,
// set the query time. After reset a clearing pass over the edge memory runs with
// in_ready_o low. One result is held in the output register while the next item
// is taken; a stalled output only delays the following result.
`timescale 1ns / 1ps
`default_nettype none

module graph_shortest_path_engine import gsp_pkg::*; #(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic [ID_W-1:0]          from_vertex_i,
  input  wire logic [ID_W-1:0]          to_vertex_i,
  input  wire logic signed [WRAW_W-1:0] weight_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          status_o,
  output logic [DIST_W-1:0]             path_length_o
);

  gsp_cmd_t  cmd;
  gsp_stat_t stat;

  gsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  gsp_dp #(
    .NUM_VERTICES(NUM_VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .from_vertex_i(from_vertex_i),
    .to_vertex_i  (to_vertex_i),
    .weight_i     (weight_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .path_length_o(path_length_o)
  );

endmodule

`default_nettype wire

>>> verif/graph_shortest_path_engine_tb.sv
// Self-checking testbench for graph_shortest_path_engine.
// Depends on gsp_pkg and the engine RTL; a scoreboard class holds a graph model
// and predicts status and path length for every transferred operation.
`timescale 1ns / 1ps

module graph_shortest_path_engine_tb;
  import gsp_pkg::*;

  localparam int NV    = NUM_VERTICES_DEF;
  localparam int WMAX  = (1 << WEIGHT_BITS_DEF) - 1;
  localparam int N_RND = 70;

  // op codes with no defined operation
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic              status;
    logic [DIST_W-1:0] len;
  } gsp_res_t;

  class path_scoreboard;
    bit              vtx_on[NV];
    bit              edge_on[NV][NV];
    int unsigned     edge_w[NV][NV];
    gsp_res_t        pending[$];
    int              errors;
    int              n_checked;

    function gsp_res_t shortest(int src, int dst);
      int unsigned dist_v[NV];
      bit          done[NV];
      int          best;
      int unsigned best_d;
      longint      cand;
      gsp_res_t    r;
      for (int i = 0; i < NV; i++) begin
        dist_v[i] = DIST_INF;
        done[i] = 0;
      end
      dist_v[src] = 0;
      forever begin
        best = NV;
        best_d = DIST_INF;
        for (int i = 0; i < NV; i++)
          if (vtx_on[i] && !done[i] && dist_v[i] < best_d) begin
            best_d = dist_v[i];
            best = i;
          end
        if (best == NV) break;
        done[best] = 1;
        for (int v = 0; v < NV; v++) begin
          if (!edge_on[best][v] || !vtx_on[v]) continue;
          cand = longint'(best_d) + edge_w[best][v];
          if (cand > DIST_INF - 1) cand = DIST_INF - 1;
          if (dist_v[v] > cand) dist_v[v] = 32'(cand);
        end
      end
      r.status = 1;
      r.len = '0;
      if (dist_v[dst] < DIST_INF) begin
        r.status = 0;
        r.len = DIST_W'(dist_v[dst]);
      end
      return r;
    endfunction

    function void note_op(logic [OP_W-1:0] op, int a, int b, logic signed [15:0] w);
      gsp_res_t r;
      r.status = 1;
      r.len = '0;
      case (op)
        OP_VINS: if (!vtx_on[a]) begin
          vtx_on[a] = 1;
          r.status = 0;
        end
        OP_VDEL: if (vtx_on[a]) begin
          for (int i = 0; i < NV; i++) begin
            edge_on[i][a] = 0;
            edge_on[a][i] = 0;
          end
          vtx_on[a] = 0;
          r.status = 0;
        end
        OP_EINS: if (vtx_on[a] && vtx_on[b] && w >= 0 && w <= WMAX && !edge_on[a][b]) begin
          edge_on[a][b] = 1;
          edge_w[a][b] = w;
          r.status = 0;
        end
        OP_EDEL: if (vtx_on[a] && vtx_on[b]) begin
          edge_on[a][b] = 0;
          r.status = 0;
        end
        OP_QRY: if (vtx_on[a] && vtx_on[b]) r = shortest(a, b);
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic status, logic [DIST_W-1:0] len);
      gsp_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d len=%0d", $time, status, len);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (status !== e.status) begin
        $display("%0t: status mismatch exp=%0d act=%0d", $time, e.status, status);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: path_length mismatch exp=%0d act=%0d", $time, e.len, len);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 0;
  logic                     rst_ni = 0;
  logic                     in_valid_i = 0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i = '0;
  logic [ID_W-1:0]          from_vertex_i = '0;
  logic [ID_W-1:0]          to_vertex_i = '0;
  logic signed [WRAW_W-1:0] weight_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 0;
  logic                     status_o;
  logic [DIST_W-1:0]        path_length_o;

  path_scoreboard sb = new();
  bit             hold_off = 0;
  int             n_query = 0;

  graph_shortest_path_engine u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .from_vertex_i,
    .to_vertex_i, .weight_i, .out_valid_o, .out_ready_i, .status_o, .path_length_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // scoreboard sees both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_op(op_i, from_vertex_i, to_vertex_i, weight_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(status_o, path_length_o);
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int pat;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (3000) @(negedge clk_i);
        hold_off = 0;
      end
      pat = $urandom_range(0, 9);
      out_ready_i <= (pat < 6) || (pat == 9 && $urandom_range(0, 1));
    end
  end

  // one transfer; valid stays high until accepted
  task automatic send_op(logic [OP_W-1:0] op, int a, int b, logic signed [15:0] w);
    op_i <= op;
    from_vertex_i <= ID_W'(a);
    to_vertex_i <= ID_W'(b);
    weight_i <= w;
    in_valid_i <= 1;
    if (op == OP_QRY) n_query++;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic rand_op(bit wellformed);
    int a, b, k;
    logic signed [15:0] w;
    a = wellformed ? $urandom_range(0, 15) : $urandom_range(0, NV - 1);
    b = wellformed ? $urandom_range(0, 15) : $urandom_range(0, NV - 1);
    w = wellformed ? 16'($urandom_range(0, 200)) : 16'($urandom());
    k = $urandom_range(0, 19);
    if (!wellformed && k == 19) send_op(OP_W'(OP_UNDEF_LO + $urandom_range(0, 2)), a, b, w);
    else if (k < 4) send_op(OP_VINS, a, b, w);
    else if (k < 5) send_op(OP_VDEL, a, b, w);
    else if (k < 11) send_op(OP_EINS, a, b, w);
    else if (k < 13) send_op(OP_EDEL, a, b, w);
    else send_op(OP_QRY, a, b, w);
  endtask

  initial begin
    int burst;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: extremes of ids and weights, each op and error case
    send_op(OP_VINS, 0, 0, 0);
    send_op(OP_VINS, 63, 0, 0);
    send_op(OP_VINS, 0, 0, 0);          // already present
    send_op(OP_VINS, 5, 0, 0);
    send_op(OP_EINS, 0, 63, WMAX);
    send_op(OP_EINS, 63, 5, 0);         // zero weight
    send_op(OP_EINS, 0, 5, -16'sd1);    // negative
    send_op(OP_EINS, 0, 5, 16'sh7FFF);
    send_op(OP_EINS, 0, 5, 16'sh8000);  // most negative
    send_op(OP_EINS, 0, 63, 1);         // duplicate
    send_op(OP_EINS, 0, 7, 1);          // absent end
    send_op(OP_QRY, 0, 5, 0);
    send_op(OP_QRY, 63, 63, 0);         // source is destination
    send_op(OP_QRY, 5, 0, 0);           // unreachable
    send_op(OP_QRY, 0, 9, 0);           // absent end
    send_op(OP_EDEL, 0, 5, 0);
    send_op(OP_EDEL, 0, 5, 0);          // missing edge still ok
    send_op(OP_EDEL, 0, 9, 0);
    send_op(OP_QRY, 0, 5, 0);
    send_op(OP_UNDEF_LO, 42, 21, 16'sh5555);  // undefined op codes
    send_op(OP_UNDEF_HI, 21, 42, 16'shAAAA);
    send_op(OP_VDEL, 63, 0, 0);
    send_op(OP_VDEL, 63, 0, 0);         // absent
    send_op(OP_QRY, 0, 5, 0);
    send_op(OP_VDEL, 0, 0, 0);

    hold_off = 1;                       // long receiver stall while offering items
    for (int i = 0; i < 8; i++) send_op(OP_VINS, i, 0, 0);

    for (int i = 0; i < N_RND; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && i < N_RND; j++, i++) rand_op($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 3) != 0) idle_gap();
    end
    in_valid_i <= 0;

    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results, including %0d queries, across all op codes.",
             sb.n_checked, n_query);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("graph_shortest_path_engine_tb: PASS");
    else $display("graph_shortest_path_engine_tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("graph_shortest_path_engine_tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_ram.sv
hw/rtl/gsp_dp.sv
hw/rtl/gsp_ctrl.sv
hw/rtl/graph_shortest_path_engine.sv
verif/graph_shortest_path_engine_tb.sv
